// File: rtl/spgc_pkg.sv
`default_nettype none

package spgc_pkg;

   // stream geometry
   localparam int MAX_LEN   = 15;
   localparam int POS_BITS  = 32;
   localparam int WIN_DEPTH = MAX_LEN - 1;
   localparam int N_CELLS   = MAX_LEN - 1;
   localparam int FILL_W    = $clog2(MAX_LEN);

   // field widths
   localparam int SYM_W = 8;
   localparam int LEN_W = 4;
   localparam int GAP_W = 33;
   localparam int CNT_W = 32;

   // gap arithmetic width, wide enough for position minus a position plus one
   localparam int DIFF_W = (POS_BITS + 2 > GAP_W + 1) ? POS_BITS + 2 : GAP_W + 1;

   localparam logic signed [DIFF_W-1:0] GAP_HIGH =
      (DIFF_W'(1) <<< 32) - DIFF_W'(2);
   localparam logic [CNT_W-1:0]    CNT_MAX = {CNT_W{1'b1}};
   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

   // control handed to one cell of the row
   typedef struct packed {
      logic                accept;
      logic                take;
      logic [SYM_W-1:0]    cur;
      logic [SYM_W-1:0]    win_in;
      logic                pal_in;
      logic                len_ok;
      logic [POS_BITS-1:0] pos;
      logic [POS_BITS:0]   pos_p1;
      logic [POS_BITS:0]   first_sub;
   } cell_ctl_type;

   // status returned by one cell
   typedef struct packed {
      logic                     pend;
      logic                     pal;
      logic [SYM_W-1:0]         tap;
      logic signed [GAP_W-1:0]  gap;
      logic [CNT_W-1:0]         count;
   } cell_sts_type;

endpackage

`default_nettype wire

// File: rtl/spgc_cell.sv
`default_nettype none

module spgc_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire spgc_pkg::cell_ctl_type ctl,
   output spgc_pkg::cell_sts_type      sts
);
   import spgc_pkg::*;

   logic                    pend_ff, pend_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    seen_ff, seen_in;
   logic [POS_BITS:0]       lastp1_ff, lastp1_in;
   logic [SYM_W-1:0]        tap_ff, tap_in;
   logic                    pal_ff, pal_in;
   logic signed [GAP_W-1:0] gap_ff, gap_in;

   logic                     pal_now;
   logic                     hit;
   logic [POS_BITS:0]        sub;
   logic signed [DIFF_W-1:0] diff;
   logic signed [GAP_W-1:0]  gap_val;

   // extend the palindrome of length two shorter that ended one symbol back
   assign pal_now = (ctl.cur == tap_ff) & ctl.pal_in;
   assign hit     = pal_now & ctl.len_ok;

   // gap from the last hit position, or from the reset centre of zero
   assign sub  = seen_ff ? lastp1_ff : ctl.first_sub;
   assign diff = $signed({{(DIFF_W-POS_BITS){1'b0}}, ctl.pos})
               - $signed({{(DIFF_W-POS_BITS-1){1'b0}}, sub});
   assign gap_val = (diff > GAP_HIGH) ? GAP_HIGH[GAP_W-1:0] : diff[GAP_W-1:0];

   // advance the tap and the pending result on each transfer
   always_comb begin
      pend_in   = pend_ff;
      count_in  = count_ff;
      seen_in   = seen_ff;
      lastp1_in = lastp1_ff;
      tap_in    = tap_ff;
      pal_in    = pal_ff;
      gap_in    = gap_ff;
      if (ctl.take) begin
         pend_in = 1'b0;
      end
      if (ctl.accept) begin
         pend_in = hit;
         tap_in  = ctl.win_in;
         pal_in  = pal_now;
         if (hit) begin
            if (count_ff != CNT_MAX) begin
               count_in = count_ff + CNT_W'(1);
            end
            seen_in   = 1'b1;
            lastp1_in = ctl.pos_p1;
            gap_in    = gap_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         count_ff <= '0;
         seen_ff  <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         count_ff <= count_in;
         seen_ff  <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      lastp1_ff <= lastp1_in;
      tap_ff    <= tap_in;
      pal_ff    <= pal_in;
      gap_ff    <= gap_in;
   end

   assign sts.pend  = pend_ff;
   assign sts.pal   = pal_ff;
   assign sts.tap   = tap_ff;
   assign sts.gap   = gap_ff;
   assign sts.count = count_ff;

endmodule

`default_nettype wire

// File: rtl/stream_palindrome_gap_counter.sv
// Streaming palindrome gap counter. Each transfer on req_ carries one byte of a stream;
// for every length from 2 to 15 whose last symbols read the same both ways, one result
// leaves on rsp_ in increasing length order, carrying the length, the hit count for that
// length (saturating) and the gap between this left centre and the previous one of the
// same length; rsp_last_of_run marks the final result of a symbol. A row of 14 cells,
// one per length, holds the symbol history, the palindrome flags and per-length state.
// A symbol's results drain from the cell row into the output register one per cycle while
// rsp_ does not stall, and the next symbol is taken in the cycle the last of them moves
// out; a symbol without hits does not hold up the input.
`default_nettype none

module stream_palindrome_gap_counter (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [spgc_pkg::SYM_W-1:0]            req_symbol,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [spgc_pkg::LEN_W-1:0]                 rsp_pal_length,
   output logic signed [spgc_pkg::GAP_W-1:0]          rsp_gap,
   output logic [spgc_pkg::CNT_W-1:0]                 rsp_running_count,
   output logic                                       rsp_last_of_run
);
   import spgc_pkg::*;

   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic signed [GAP_W-1:0] gap_ff, gap_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                last_ff, last_in;

   cell_ctl_type        ctl [N_CELLS];
   cell_sts_type        sts [N_CELLS];
   logic [N_CELLS-1:0]  pending;
   logic [N_CELLS-1:0]  pick;
   logic [N_CELLS-1:0]  pend_left;
   logic                accept;
   logic                load;
   logic [POS_BITS:0]   pos_p1;

   // pick the shortest pending length and move it out when the output register frees
   assign pick      = pending & (~pending + N_CELLS'(1));
   assign load      = (|pending) & (~rsp_valid_ff | ~rsp_stall);
   assign pend_left = pending & ~(load ? pick : '0);
   assign req_stall = |pend_left;
   assign accept    = req_valid & ~req_stall;
   assign pos_p1    = {1'b0, pos_ff} + (POS_BITS+1)'(1);

   // build the cell row
   for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
      assign ctl[i].accept    = accept;
      assign ctl[i].take      = load & pick[i];
      assign ctl[i].cur       = req_symbol;
      assign ctl[i].pal_in    = (i < 2) ? 1'b1 : sts[(i < 2) ? i : i-2].pal;
      assign ctl[i].win_in    = (i == 0) ? req_symbol : sts[(i == 0) ? 0 : i-1].tap;
      assign ctl[i].len_ok    = fill_ff > FILL_W'(i);
      assign ctl[i].pos       = pos_ff;
      assign ctl[i].pos_p1    = pos_p1;
      assign ctl[i].first_sub = (POS_BITS+1)'((i + 3) / 2 + 1);
      assign pending[i]       = sts[i].pend;

      spgc_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl[i]),
         .sts   (sts[i])
      );
   end

   // select the picked cell's result
   always_comb begin
      len_in = len_ff;
      gap_in = gap_ff;
      cnt_in = cnt_ff;
      last_in = last_ff;
      if (load) begin
         len_in  = '0;
         gap_in  = '0;
         cnt_in  = '0;
         last_in = (pending & ~pick) == '0;
         for (int i = 0; i < N_CELLS; i++) begin
            if (pick[i]) begin
               len_in = len_in | LEN_W'(i + 2);
               gap_in = gap_in | sts[i].gap;
               cnt_in = cnt_in | sts[i].count;
            end
         end
      end
   end

   // hold the output register until its transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // advance fill level and position on each input transfer
   always_comb begin
      fill_in = fill_ff;
      pos_in  = pos_ff;
      if (accept) begin
         if (fill_ff != FILL_W'(WIN_DEPTH)) begin
            fill_in = fill_ff + FILL_W'(1);
         end
         if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + POS_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      gap_ff  <= gap_in;
      cnt_ff  <= cnt_in;
      last_ff <= last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pal_length    = len_ff;
   assign rsp_gap           = gap_ff;
   assign rsp_running_count = cnt_ff;
   assign rsp_last_of_run   = last_ff;

endmodule

`default_nettype wire
